/* rtl/ptc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and helpers for pressure/temperature compensation.
// ----------------------------------------------------------------------------
package ptc_pkg;

	localparam int unsigned W            = 32;
	localparam int unsigned RAW_W        = 20;
	localparam int unsigned IDX_W        = 3;
	localparam int unsigned DIV_STEPS    = W;
	localparam int unsigned FRONT_STAGES = 12;

	localparam logic [IDX_W-1:0] REG_T1    = 3'd0;
	localparam logic [IDX_W-1:0] REG_T2_T3 = 3'd1;
	localparam logic [IDX_W-1:0] REG_P1    = 3'd2;
	localparam logic [IDX_W-1:0] REG_P2_P3 = 3'd3;
	localparam logic [IDX_W-1:0] REG_P4_P5 = 3'd4;
	localparam logic [IDX_W-1:0] REG_P6_P7 = 3'd5;
	localparam logic [IDX_W-1:0] REG_P8_P9 = 3'd6;

	localparam logic [W-1:0] FINE_OFS  = 32'd64000;
	localparam logic [W-1:0] RAW_FULL  = 32'd1048576;
	localparam logic [W-1:0] P_SCALE   = 32'd3125;
	localparam logic [W-1:0] HALF_WORD = 32'h8000_0000;
	localparam logic [W-1:0] P1_OFS    = 32'd32768;
	localparam logic [W-1:0] T_ROUND   = 32'd128;

	typedef struct packed {
		logic [15:0] t1;
		logic [31:0] t2_t3;
		logic [15:0] p1;
		logic [31:0] p2_p3;
		logic [31:0] p4_p5;
		logic [31:0] p6_p7;
		logic [31:0] p8_p9;
	} cal_t;

	typedef struct packed {
		logic [W-1:0] temp;
		logic         zero;
		logic         big;
	} side_t;

	function automatic logic [W-1:0] asr(logic [W-1:0] v, int unsigned n);
		return W'($signed(v) >>> n);
	endfunction

	function automatic logic [W-1:0] hi16(logic [31:0] v);
		return {{16{v[31]}}, v[31:16]};
	endfunction

	function automatic logic [W-1:0] lo16(logic [31:0] v);
		return {{16{v[15]}}, v[15:0]};
	endfunction

endpackage
`default_nettype wire

/* rtl/ptc_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_sample_if / ptc_result_if
// Valid/ready channels carrying raw samples and compensated results.
// ----------------------------------------------------------------------------
interface ptc_sample_if;
	logic                          valid;
	logic                          ready;
	logic [ptc_pkg::RAW_W-1:0]     raw_temperature;
	logic [ptc_pkg::RAW_W-1:0]     raw_pressure;
	modport source (output valid, raw_temperature, raw_pressure, input ready);
	modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface ptc_result_if;
	logic                          valid;
	logic                          ready;
	logic signed [ptc_pkg::W-1:0]  temperature_centi;
	logic [ptc_pkg::W-1:0]         pressure_pa;
	logic                          divisor_zero;
	modport source (output valid, temperature_centi, pressure_pa, divisor_zero,
		input ready);
	modport sink   (input valid, temperature_centi, pressure_pa, divisor_zero,
		output ready);
endinterface
`default_nettype wire

/* rtl/ptc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_front
// Temperature path and pressure path up to the divider, twelve stages.
// ----------------------------------------------------------------------------
module ptc_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire logic [ptc_pkg::RAW_W-1:0]  raw_t,
	input  wire logic [ptc_pkg::RAW_W-1:0]  raw_p,
	input  wire ptc_pkg::cal_t              cal,
	output logic                            out_valid,
	output logic [ptc_pkg::W-1:0]           dividend,
	output logic [ptc_pkg::W-1:0]           divisor,
	output ptc_pkg::side_t                  side
);
	typedef logic [ptc_pkg::W-1:0] w_t;

	logic [ptc_pkg::FRONT_STAGES:1] v;
	w_t t1, t2, t3, p1, p2, p3, p4, p5, p6;
	w_t rt, rp;

	w_t x_s1, d_s1, rp_s1;
	w_t m1_s2, dd_s2, rp_s2;
	w_t a_s3, m2_s3, rp_s3;
	w_t fine_s4, rp_s4;
	w_t temp_s5, pa_s5, q_s5, rp_s5;
	w_t temp_s6, qq_s6, mp5_s6, mp2_s6, rp_s6;
	w_t temp_s7, b1_s7, mp3_s7, mp5_s7, mp2_s7, rp_s7;
	w_t temp_s8, b_s8, a_s8, rp_s8;
	w_t temp_s9, a2_s9, b12_s9, rp_s9;
	w_t temp_s10, a3_s10, num_s10;
	w_t temp_s11, p0_s11, a3_s11;
	w_t temp_s12, n_s12, dv_s12;
	logic zero_s12, big_s12;
	w_t b_c;

	assign t1 = {16'd0, cal.t1};
	assign t2 = ptc_pkg::hi16(cal.t2_t3);
	assign t3 = ptc_pkg::lo16(cal.t2_t3);
	assign p1 = {16'd0, cal.p1};
	assign p2 = ptc_pkg::hi16(cal.p2_p3);
	assign p3 = ptc_pkg::lo16(cal.p2_p3);
	assign p4 = ptc_pkg::hi16(cal.p4_p5);
	assign p5 = ptc_pkg::lo16(cal.p4_p5);
	assign p6 = ptc_pkg::hi16(cal.p6_p7);
	assign rt = {12'd0, raw_t};
	assign rp = {12'd0, raw_p};
	assign b_c = b1_s7 + (mp5_s7 << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else if (en) begin
			v <= {v[ptc_pkg::FRONT_STAGES-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= (rt >> 3) - (t1 << 1);
			d_s1  <= (rt >> 4) - t1;
			rp_s1 <= rp;

			m1_s2 <= x_s1 * t2;
			dd_s2 <= d_s1 * d_s1;
			rp_s2 <= rp_s1;

			a_s3  <= ptc_pkg::asr(m1_s2, 11);
			m2_s3 <= ptc_pkg::asr(dd_s2, 12) * t3;
			rp_s3 <= rp_s2;

			fine_s4 <= a_s3 + ptc_pkg::asr(m2_s3, 14);
			rp_s4   <= rp_s3;

			temp_s5 <= ptc_pkg::asr(fine_s4 * 32'd5 + ptc_pkg::T_ROUND, 8);
			pa_s5   <= ptc_pkg::asr(fine_s4, 1) - ptc_pkg::FINE_OFS;
			q_s5    <= ptc_pkg::asr(ptc_pkg::asr(fine_s4, 1) - ptc_pkg::FINE_OFS, 2);
			rp_s5   <= rp_s4;

			temp_s6 <= temp_s5;
			qq_s6   <= q_s5 * q_s5;
			mp5_s6  <= pa_s5 * p5;
			mp2_s6  <= p2 * pa_s5;
			rp_s6   <= rp_s5;

			temp_s7 <= temp_s6;
			b1_s7   <= ptc_pkg::asr(qq_s6, 11) * p6;
			mp3_s7  <= p3 * ptc_pkg::asr(qq_s6, 13);
			mp5_s7  <= mp5_s6;
			mp2_s7  <= mp2_s6;
			rp_s7   <= rp_s6;

			temp_s8 <= temp_s7;
			b_s8    <= ptc_pkg::asr(b_c, 2) + (p4 << 16);
			a_s8    <= ptc_pkg::asr(ptc_pkg::asr(mp3_s7, 3) + ptc_pkg::asr(mp2_s7, 1), 18);
			rp_s8   <= rp_s7;

			temp_s9 <= temp_s8;
			a2_s9   <= (ptc_pkg::P1_OFS + a_s8) * p1;
			b12_s9  <= ptc_pkg::asr(b_s8, 12);
			rp_s9   <= rp_s8;

			temp_s10 <= temp_s9;
			a3_s10   <= ptc_pkg::asr(a2_s9, 15);
			num_s10  <= (ptc_pkg::RAW_FULL - rp_s9) - b12_s9;

			temp_s11 <= temp_s10;
			p0_s11   <= num_s10 * ptc_pkg::P_SCALE;
			a3_s11   <= a3_s10;

			temp_s12 <= temp_s11;
			big_s12  <= p0_s11 >= ptc_pkg::HALF_WORD;
			n_s12    <= (p0_s11 >= ptc_pkg::HALF_WORD) ? p0_s11 : (p0_s11 << 1);
			dv_s12   <= a3_s11;
			zero_s12 <= a3_s11 == '0;
		end
	end

	assign out_valid = v[ptc_pkg::FRONT_STAGES];
	assign dividend  = n_s12;
	assign divisor   = dv_s12;
	assign side      = '{temp: temp_s12, zero: zero_s12, big: big_s12};
endmodule
`default_nettype wire

/* rtl/ptc_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_div
// Restoring unsigned divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module ptc_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire logic [ptc_pkg::W-1:0]     dividend,
	input  wire logic [ptc_pkg::W-1:0]     divisor,
	input  wire ptc_pkg::side_t            side_in,
	output logic                           out_valid,
	output logic [ptc_pkg::W-1:0]          quotient,
	output ptc_pkg::side_t                 side_out
);
	localparam int unsigned S = ptc_pkg::DIV_STEPS;
	localparam int unsigned W = ptc_pkg::W;

	logic [S:0]        v_s;
	logic [W-1:0]      rem_s  [S+1];
	logic [W-1:0]      num_s  [S+1];
	logic [W-1:0]      quo_s  [S+1];
	logic [W-1:0]      dv_s   [S+1];
	ptc_pkg::side_t    side_s [S+1];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign num_s[0]  = dividend;
	assign quo_s[0]  = '0;
	assign dv_s[0]   = divisor;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < S; k++) begin : g_step
		logic [W:0] trial;
		logic       fit;
		assign trial = {rem_s[k], num_s[k][W-1]};
		assign fit   = trial >= {1'b0, dv_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= fit ? W'(trial - {1'b0, dv_s[k]}) : trial[W-1:0];
				num_s[k+1]  <= num_s[k] << 1;
				quo_s[k+1]  <= {quo_s[k][W-2:0], fit};
				dv_s[k+1]   <= dv_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[S];
	assign quotient  = quo_s[S];
	assign side_out  = side_s[S];
endmodule
`default_nettype wire

/* rtl/ptc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_back
// Pressure correction after the divide; last stage is the output register.
// ----------------------------------------------------------------------------
module ptc_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire logic [ptc_pkg::W-1:0]     quotient,
	input  wire ptc_pkg::side_t            side_in,
	input  wire ptc_pkg::cal_t             cal,
	output logic                           out_valid,
	output logic [ptc_pkg::W-1:0]          temp,
	output logic [ptc_pkg::W-1:0]          press,
	output logic                           zero
);
	typedef logic [ptc_pkg::W-1:0] w_t;

	logic [3:1] v;
	w_t p, p7, p8, p9;
	w_t p_s1, m_s1, m8_s1, temp_s1;
	w_t p_s2, m9_s2, b_s2, temp_s2;
	w_t p_s3, temp_s3;
	logic zero_s1, zero_s2, zero_s3;
	w_t sum_c;

	assign p7 = ptc_pkg::lo16(cal.p6_p7);
	assign p8 = ptc_pkg::hi16(cal.p8_p9);
	assign p9 = ptc_pkg::lo16(cal.p8_p9);
	assign p  = side_in.big ? (quotient << 1) : quotient;
	assign sum_c = ptc_pkg::asr(m9_s2, 12) + b_s2 + p7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else if (en) begin
			v <= {v[2:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= p;
			m_s1    <= (p >> 3) * (p >> 3);
			m8_s1   <= (p >> 2) * p8;
			temp_s1 <= side_in.temp;
			zero_s1 <= side_in.zero;

			p_s2    <= p_s1;
			m9_s2   <= p9 * (m_s1 >> 13);
			b_s2    <= ptc_pkg::asr(m8_s1, 13);
			temp_s2 <= temp_s1;
			zero_s2 <= zero_s1;

			p_s3    <= zero_s2 ? '0 : p_s2 + ptc_pkg::asr(sum_c, 4);
			temp_s3 <= temp_s2;
			zero_s3 <= zero_s2;
		end
	end

	assign out_valid = v[3];
	assign temp      = temp_s3;
	assign press     = p_s3;
	assign zero      = zero_s3;
endmodule
`default_nettype wire

/* rtl/pressure_temperature_compensation.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// 32-bit integer barometric compensation, fully pipelined.
// ----------------------------------------------------------------------------
// A transaction on sample carries one raw temperature and one raw pressure
// reading; each yields one transaction on result with temperature in 0.01
// degC, pressure in Pa and the divisor-zero flag.
// Calibration words are written through cfg_we/cfg_idx/cfg_wdata; the user
// is to do so only while the pipeline is empty, which the block itself does
// not enforce. Unknown indexes are dropped. From sample accept to result
// valid there are 12 stages for temperature and the pressure prescale, 32 for
// the bit-per-stage divider, 3 for the final correction with the output register.
// Throughput is one transaction per cycle, set by the pipelined divider.
// A stalled result freezes the whole pipeline; sample.ready then follows
// result.ready, nothing is lost or repeated.
// Reset clears all valid bits and the calibration words to zero.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	ptc_sample_if.sink                     sample,
	ptc_result_if.source                   result,
	input  wire logic                      cfg_we,
	input  wire logic [ptc_pkg::IDX_W-1:0] cfg_idx,
	input  wire logic [ptc_pkg::W-1:0]     cfg_wdata
);
	ptc_pkg::cal_t cal_q;
	ptc_pkg::side_t f_side, d_side;
	logic en, f_v, d_v, b_v;
	logic [ptc_pkg::W-1:0] f_n, f_d, d_q, b_t, b_p;
	logic b_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ptc_pkg::REG_T1:    cal_q.t1    <= cfg_wdata[15:0];
				ptc_pkg::REG_T2_T3: cal_q.t2_t3 <= cfg_wdata;
				ptc_pkg::REG_P1:    cal_q.p1    <= cfg_wdata[15:0];
				ptc_pkg::REG_P2_P3: cal_q.p2_p3 <= cfg_wdata;
				ptc_pkg::REG_P4_P5: cal_q.p4_p5 <= cfg_wdata;
				ptc_pkg::REG_P6_P7: cal_q.p6_p7 <= cfg_wdata;
				ptc_pkg::REG_P8_P9: cal_q.p8_p9 <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en = !b_v || result.ready;
	assign sample.ready = en;

	ptc_front u_front (
		.clk, .arst_n, .en,
		.in_valid (sample.valid),
		.raw_t    (sample.raw_temperature),
		.raw_p    (sample.raw_pressure),
		.cal      (cal_q),
		.out_valid(f_v),
		.dividend (f_n),
		.divisor  (f_d),
		.side     (f_side)
	);

	ptc_div u_div (
		.clk, .arst_n, .en,
		.in_valid (f_v),
		.dividend (f_n),
		.divisor  (f_d),
		.side_in  (f_side),
		.out_valid(d_v),
		.quotient (d_q),
		.side_out (d_side)
	);

	ptc_back u_back (
		.clk, .arst_n, .en,
		.in_valid (d_v),
		.quotient (d_q),
		.side_in  (d_side),
		.cal      (cal_q),
		.out_valid(b_v),
		.temp     (b_t),
		.press    (b_p),
		.zero     (b_z)
	);

	assign result.valid             = b_v;
	assign result.temperature_centi = $signed(b_t);
	assign result.pressure_pa       = b_p;
	assign result.divisor_zero      = b_z;

	a_zero_press: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.divisor_zero |-> result.pressure_pa == '0)
		else $error("pressure not cleared on zero divisor");

	a_bad_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_idx > ptc_pkg::REG_P8_P9 |=> $stable(cal_q))
		else $error("unknown register index changed calibration");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(f_v) && $stable(d_v) && $stable(f_n))
		else $error("pipeline moved during stall");
endmodule
`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pressure_temperature_compensation: a directed table
// of readings and calibration sets, then constrained-free random readings
// under several idling mixes, scored against a bit-exact integer predictor.
// ----------------------------------------------------------------------------
module tb_top;
	localparam logic [ptc_pkg::IDX_W-1:0] REG_NONE = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ptc_pkg::IDX_W-1:0] cfg_idx = '0;
	logic [ptc_pkg::W-1:0] cfg_wdata = '0;

	ptc_sample_if sample ();
	ptc_result_if result ();

	pressure_temperature_compensation dut (
		.clk(clk), .arst_n(arst_n), .sample(sample.sink), .result(result.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#40000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	typedef struct {
		logic [31:0] temp;
		logic [31:0] pres;
		logic        zflag;
	} comp_t;

	logic [31:0] cal [0:6];
	comp_t       pending_q [$];
	int          errors = 0;
	int          n_sent = 0;
	int          n_got = 0;
	int          n_zero = 0;
	int          n_big = 0;
	int          src_idle = 0;
	int          snk_idle = 0;
	int          hold_cycles = 0;

	function automatic logic [31:0] sra(logic [31:0] v, int n);
		return $signed(v) >>> n;
	endfunction

	function automatic logic [31:0] sext(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic comp_t compensate(logic [19:0] rt, logic [19:0] rp);
		logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] a, b, d, fine, q, p;
		comp_t r;
		t1 = {16'd0, cal[0][15:0]};
		t2 = sext(cal[1][31:16]); t3 = sext(cal[1][15:0]);
		p1 = {16'd0, cal[2][15:0]};
		p2 = sext(cal[3][31:16]); p3 = sext(cal[3][15:0]);
		p4 = sext(cal[4][31:16]); p5 = sext(cal[4][15:0]);
		p6 = sext(cal[5][31:16]); p7 = sext(cal[5][15:0]);
		p8 = sext(cal[6][31:16]); p9 = sext(cal[6][15:0]);
		a = sra((({12'd0, rt} >> 3) - (t1 << 1)) * t2, 11);
		d = ({12'd0, rt} >> 4) - t1;
		b = sra(sra(d * d, 12) * t3, 14);
		fine = a + b;
		r.temp = sra(fine * 32'd5 + 32'd128, 8);
		a = sra(fine, 1) - 32'd64000;
		q = sra(a, 2);
		b = sra(q * q, 11) * p6;
		b = b + ((a * p5) << 1);
		b = sra(b, 2) + (p4 << 16);
		a = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * a, 1), 18);
		a = sra((32'd32768 + a) * p1, 15);
		if (a == 0) begin
			r.pres = 0;
			r.zflag = 1'b1;
		end else begin
			r.zflag = 1'b0;
			p = ((32'd1048576 - {12'd0, rp}) - sra(b, 12)) * 32'd3125;
			if (p < 32'h8000_0000) p = (p << 1) / a;
			else p = (p / a) * 32'd2;
			a = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
			b = sra((p >> 2) * p8, 13);
			r.pres = p + sra(a + b + p7, 4);
		end
		return r;
	endfunction

	task automatic write_cal(logic [ptc_pkg::IDX_W-1:0] idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx <= ptc_pkg::REG_P8_P9)
			cal[idx] = (idx == ptc_pkg::REG_T1 || idx == ptc_pkg::REG_P1) ?
				{16'd0, v[15:0]} : v;
	endtask

	task automatic drain();
		sample.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// typical factory trim
	task automatic load_typical();
		write_cal(ptc_pkg::REG_T1, 32'd27504);
		write_cal(ptc_pkg::REG_T2_T3, {16'd26435, 16'hFC18});
		write_cal(ptc_pkg::REG_P1, 32'd36477);
		write_cal(ptc_pkg::REG_P2_P3, {16'hD670, 16'd3024});
		write_cal(ptc_pkg::REG_P4_P5, {16'd2855, 16'd140});
		write_cal(ptc_pkg::REG_P6_P7, {16'hFFF9, 16'd15500});
		write_cal(ptc_pkg::REG_P8_P9, {16'hD1F0, 16'd6000});
	endtask

	task automatic load_random();
		write_cal(ptc_pkg::REG_T1, $urandom);
		write_cal(ptc_pkg::REG_T2_T3, $urandom);
		write_cal(ptc_pkg::REG_P1, $urandom);
		write_cal(ptc_pkg::REG_P2_P3, $urandom);
		write_cal(ptc_pkg::REG_P4_P5, $urandom);
		write_cal(ptc_pkg::REG_P6_P7, $urandom);
		write_cal(ptc_pkg::REG_P8_P9, $urandom);
		write_cal(REG_NONE, $urandom);
	endtask

	// valid stays high after the accept; the next send or drain decides
	task automatic send(logic [19:0] rt, logic [19:0] rp);
		comp_t e;
		while (src_idle != 0 && $urandom_range(99) < src_idle) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.raw_temperature <= rt;
		sample.raw_pressure <= rp;
		@(posedge clk);
		while (!sample.ready) @(posedge clk);
		e = compensate(rt, rp);
		pending_q.push_back(e);
		n_sent++;
	endtask

	// sink side
	initial begin
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				result.ready <= 1'b0;
				hold_cycles--;
			end else
				result.ready <= !(snk_idle != 0 && $urandom_range(99) < snk_idle);
		end
	end

	// scoreboard
	always @(posedge clk) begin
		comp_t e;
		if (arst_n && result.valid && result.ready) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				e = pending_q.pop_front();
				n_got++;
				if (e.zflag) n_zero++;
				if (result.temperature_centi !== e.temp) begin
					$error("temperature_centi exp %h got %h", e.temp, result.temperature_centi);
					errors++;
				end
				if (result.pressure_pa !== e.pres) begin
					$error("pressure_pa exp %h got %h", e.pres, result.pressure_pa);
					errors++;
				end
				if (result.divisor_zero !== e.zflag) begin
					$error("divisor_zero exp %b got %b", e.zflag, result.divisor_zero);
					errors++;
				end
			end
		end
	end

	typedef struct {
		logic        cfg;
		logic [19:0] rt;
		logic [19:0] rp;
		logic        chk;
		logic [31:0] temp;
		logic [31:0] pres;
		logic        zflag;
	} row_t;

	row_t dir_tab [] = '{
		// reset calibration: divisor zero, fine temp from zero words
		'{1'b0, 20'd0, 20'd0, 1'b1, 32'd0, 32'd0, 1'b1},
		'{1'b0, 20'hFFFFF, 20'hFFFFF, 1'b1, 32'd0, 32'd0, 1'b1},
		'{1'b0, 20'h80000, 20'h00001, 1'b1, 32'd0, 32'd0, 1'b1},
		'{1'b1, 20'd519888, 20'd415148, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 20'd0, 20'd0, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 20'hFFFFF, 20'hFFFFF, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 20'hFFFFF, 20'd0, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 20'd0, 20'hFFFFF, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 20'hAAAAA, 20'h55555, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 20'h55555, 20'hAAAAA, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 20'd440000, 20'd200, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 20'd600000, 20'd900000, 1'b0, 32'd0, 32'd0, 1'b0}
	};

	initial begin
		logic [19:0] rt, rp;
		for (int i = 0; i < 7; i++) cal[i] = '0;
		sample.valid = 1'b0;
		sample.raw_temperature = '0;
		sample.raw_pressure = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg) begin
				drain();
				load_typical();
			end
			send(dir_tab[i].rt, dir_tab[i].rp);
			if (dir_tab[i].chk) begin
				pending_q[$].temp = dir_tab[i].temp;
				pending_q[$].pres = dir_tab[i].pres;
				pending_q[$].zflag = dir_tab[i].zflag;
			end
		end
		drain();
		// extreme calibration words, small P1 so the divisor can vanish
		write_cal(ptc_pkg::REG_T1, 32'hFFFF);
		write_cal(ptc_pkg::REG_T2_T3, 32'h7FFF_8000);
		write_cal(ptc_pkg::REG_P1, 32'd1);
		write_cal(ptc_pkg::REG_P2_P3, 32'h8000_7FFF);
		write_cal(ptc_pkg::REG_P4_P5, 32'h7FFF_8000);
		write_cal(ptc_pkg::REG_P6_P7, 32'h8000_7FFF);
		write_cal(ptc_pkg::REG_P8_P9, 32'h7FFF_8000);
		send(20'd0, 20'd0);
		send(20'hFFFFF, 20'hFFFFF);
		send(20'h7FFFF, 20'h80000);
		drain();

		// phases: calibration set x idling mix
		for (int ph = 0; ph < 9; ph++) begin
			case (ph % 3)
				0: begin src_idle = 6; snk_idle = 87; end
				1: begin src_idle = 87; snk_idle = 6; end
				default: begin src_idle = 0; snk_idle = 0; end
			endcase
			drain();
			if (ph == 0) load_typical();
			else if (ph == 8) begin
				write_cal(ptc_pkg::REG_T1, 32'd0);
				write_cal(ptc_pkg::REG_T2_T3, 32'd0);
				write_cal(ptc_pkg::REG_P1, 32'd0);
				write_cal(ptc_pkg::REG_P2_P3, 32'd0);
				write_cal(ptc_pkg::REG_P4_P5, 32'd0);
				write_cal(ptc_pkg::REG_P6_P7, 32'd0);
				write_cal(ptc_pkg::REG_P8_P9, 32'hFFFF_FFFF);
			end else if (ph % 2) load_random();
			else load_typical();
			if (ph == 2) hold_cycles = 200;
			for (int k = 0; k < 80; k++) begin
				if ($urandom_range(3) != 0) begin
					rt = 20'($urandom_range(380000, 620000));
					rp = 20'($urandom_range(150000, 600000));
				end else begin
					rt = 20'($urandom);
					rp = 20'($urandom);
				end
				send(rt, rp);
			end
			if (ph == 4) drain();
		end
		drain();
		repeat (60) @(posedge clk);
		$display("covered %0d readings, %0d results, %0d with zero divisor",
			n_sent, n_got, n_zero);
		$display("calibration: reset, typical, extreme and random sets under three idle mixes");
		if (errors == 0 && pending_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
